// ----- design/itch_pkg.sv -----
// Package: message type table, field layouts and shared types for the ITCH field extractor.
package itch_pkg;

    localparam int NumTypes = 23;
    localparam int MaxFields = 18;   // 3 header + 15 body
    localparam int DataW = 8;
    localparam int ValueW = 64;
    localparam int FieldIdxW = 5;
    localparam int FieldBytesW = 4;
    localparam int TypeIdxW = 5;
    localparam int QueueDepth = 4;

    // Classified item passed from the front to the back.
    typedef struct packed {
        logic       bad;       // unknown type letter, emit an error result
        logic       is_type;   // type letter starting a message, no result
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic [7:0]             msg_type;
        logic [FieldIdxW-1:0]   field_index;
        logic [ValueW-1:0]      field_value;
        logic [FieldBytesW-1:0] field_bytes;
        logic                   last_field;
        logic                   bad_type;
    } t_result;

    // Type letter lookup; returns found flag and table index.
    function automatic logic [TypeIdxW:0] find_type(input logic [7:0] letter);
        logic [TypeIdxW:0] r;
        r = '0;
        unique case (letter)
            8'h53: r = {1'b1, 5'd0};   // S
            8'h52: r = {1'b1, 5'd1};   // R
            8'h48: r = {1'b1, 5'd2};   // H
            8'h59: r = {1'b1, 5'd3};   // Y
            8'h4C: r = {1'b1, 5'd4};   // L
            8'h56: r = {1'b1, 5'd5};   // V
            8'h57: r = {1'b1, 5'd6};   // W
            8'h4B: r = {1'b1, 5'd7};   // K
            8'h4A: r = {1'b1, 5'd8};   // J
            8'h68: r = {1'b1, 5'd9};   // h
            8'h41: r = {1'b1, 5'd10};  // A
            8'h46: r = {1'b1, 5'd11};  // F
            8'h45: r = {1'b1, 5'd12};  // E
            8'h43: r = {1'b1, 5'd13};  // C
            8'h58: r = {1'b1, 5'd14};  // X
            8'h44: r = {1'b1, 5'd15};  // D
            8'h55: r = {1'b1, 5'd16};  // U
            8'h50: r = {1'b1, 5'd17};  // P
            8'h51: r = {1'b1, 5'd18};  // Q
            8'h42: r = {1'b1, 5'd19};  // B
            8'h49: r = {1'b1, 5'd20};  // I
            8'h4E: r = {1'b1, 5'd21};  // N
            8'h4F: r = {1'b1, 5'd22};  // O
            default: r = '0;
        endcase
        return r;
    endfunction

    // Layout per type: width of field k, 0 past the end. 4 bits per field.
    function automatic logic [FieldBytesW-1:0] width_of(input logic [TypeIdxW-1:0] t,
                                                        input logic [FieldIdxW-1:0] k);
        logic [MaxFields*4-1:0] row;
        logic [FieldBytesW-1:0] w;
        row = '0;
        unique case (t)
            5'd0:  row = 72'h1_6_2_2;
            5'd1:  row = 72'h1_4_1_1_1_1_1_2_1_1_4_1_1_8_6_2_2;
            5'd2:  row = 72'h4_1_1_8_6_2_2;
            5'd3:  row = 72'h1_8_6_2_2;
            5'd4:  row = 72'h1_1_1_8_4_6_2_2;
            5'd5:  row = 72'h8_8_8_6_2_2;
            5'd6:  row = 72'h1_6_2_2;
            5'd7:  row = 72'h4_1_4_8_6_2_2;
            5'd8:  row = 72'h4_4_4_4_8_6_2_2;
            5'd9:  row = 72'h1_1_8_6_2_2;
            5'd10: row = 72'h4_8_4_1_8_6_2_2;
            5'd11: row = 72'h4_4_8_4_1_8_6_2_2;
            5'd12: row = 72'h8_4_8_6_2_2;
            5'd13: row = 72'h4_1_8_4_8_6_2_2;
            5'd14: row = 72'h4_8_6_2_2;
            5'd15: row = 72'h8_6_2_2;
            5'd16: row = 72'h4_4_8_8_6_2_2;
            5'd17: row = 72'h8_4_8_4_1_8_6_2_2;
            5'd18: row = 72'h1_8_4_8_8_6_2_2;
            5'd19: row = 72'h8_6_2_2;
            5'd20: row = 72'h1_1_4_4_4_8_1_8_8_6_2_2;
            5'd21: row = 72'h1_8_6_2_2;
            5'd22: row = 72'h4_4_8_4_4_4_1_8_6_2_2;
            default: row = '0;
        endcase
        w = '0;
        if (k < 5'(MaxFields)) begin
            w = row[k*4 +: 4];
        end
        return w;
    endfunction

endpackage

// ----- design/itch_front.sv -----
// Front end: accepts stream bytes and tags type letters and unknown types.
module itch_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_data_byte,
    output logic               o_valid,
    input  logic               i_ready,
    output itch_pkg::t_item    o_item
);
    // Message tracking: front knows message boundaries from the layout.
    logic                             r_in_msg;
    logic [itch_pkg::TypeIdxW-1:0]    r_tidx;
    logic [itch_pkg::FieldIdxW-1:0]   r_field;
    logic [itch_pkg::FieldBytesW-1:0] r_left;   // bytes left in current field
    logic [itch_pkg::TypeIdxW:0]      w_find;
    logic [itch_pkg::FieldBytesW-1:0] w_nextw;
    logic                             w_acc;

    assign w_find  = itch_pkg::find_type(i_data_byte);
    assign w_nextw = itch_pkg::width_of(r_tidx, r_field + 5'd1);

    // Single output register
    assign o_ready = !o_valid || i_ready;
    assign w_acc   = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid  <= 1'b0;
            r_in_msg <= 1'b0;
            r_tidx   <= '0;
            r_field  <= '0;
            r_left   <= '0;
        end else begin
            if (o_ready) o_valid <= i_valid;
            if (w_acc) begin
                o_item.data    <= i_data_byte;
                o_item.is_type <= !r_in_msg && w_find[itch_pkg::TypeIdxW];
                o_item.bad     <= !r_in_msg && !w_find[itch_pkg::TypeIdxW];
                if (!r_in_msg) begin
                    if (w_find[itch_pkg::TypeIdxW]) begin
                        r_in_msg <= 1'b1;
                        r_tidx   <= w_find[itch_pkg::TypeIdxW-1:0];
                        r_field  <= '0;
                        r_left   <= 4'd2;
                    end
                end else if (r_left == 4'd1) begin
                    if (w_nextw == '0) begin
                        r_in_msg <= 1'b0;
                    end else begin
                        r_field <= r_field + 5'd1;
                        r_left  <= w_nextw;
                    end
                end else begin
                    r_left <= r_left - 4'd1;
                end
            end
        end
    end
endmodule

// ----- design/itch_fifo.sv -----
// Short queue between front and back.
module itch_fifo #(
    parameter int Depth = itch_pkg::QueueDepth
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  itch_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output itch_pkg::t_item o_item
);
    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    itch_pkg::t_item r_mem [Depth];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic w_push, w_pop;

    assign o_ready = r_cnt != (AW+1)'(Depth);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == AW'(Depth-1)) ? '0 : r_wp + 1'b1;
            if (w_pop)  r_rp <= (r_rp == AW'(Depth-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(Depth)) else $error("queue count overflow");
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == (AW+1)'(Depth) |-> !w_push) else $error("push into full queue");
    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> !w_pop) else $error("pop from empty queue");
`endif
endmodule

// ----- design/itch_back.sv -----
// Back end: accumulates field bytes and builds result items.
module itch_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  itch_pkg::t_item   i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output itch_pkg::t_result o_res
);
    logic [7:0]                       r_type;
    logic [itch_pkg::TypeIdxW-1:0]    r_tidx;
    logic [itch_pkg::FieldIdxW-1:0]   r_field;
    logic [itch_pkg::FieldBytesW-1:0] r_left;
    logic [itch_pkg::ValueW-1:0]      r_acc;
    logic [itch_pkg::FieldBytesW-1:0] w_w, w_nextw;
    logic [itch_pkg::TypeIdxW:0]      w_find;
    logic [itch_pkg::ValueW-1:0]      w_acc;
    logic                             w_take;
    logic                             w_emit;

    assign w_find  = itch_pkg::find_type(i_item.data);
    assign w_w     = itch_pkg::width_of(r_tidx, r_field);
    assign w_nextw = itch_pkg::width_of(r_tidx, r_field + 5'd1);
    assign w_acc   = {r_acc[itch_pkg::ValueW-9:0], i_item.data};
    assign o_ready = !o_valid || i_ready;
    assign w_take  = i_valid && o_ready;
    // Item that produces a result: error or final byte of a field
    assign w_emit  = w_take && (i_item.bad || (!i_item.is_type && r_left == 4'd1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_type  <= '0;
            r_tidx  <= '0;
            r_field <= '0;
            r_left  <= '0;
            r_acc   <= '0;
        end else begin
            if (w_emit) begin
                o_valid <= 1'b1;
            end else if (o_ready) begin
                o_valid <= 1'b0;
            end
            if (w_take) begin
                priority if (i_item.bad) begin
                    o_res <= '{bad_type: 1'b1, default: '0};
                end else if (i_item.is_type) begin
                    r_type  <= i_item.data;
                    r_tidx  <= w_find[itch_pkg::TypeIdxW-1:0];
                    r_field <= '0;
                    r_left  <= 4'd2;
                    r_acc   <= '0;
                end else if (r_left == 4'd1) begin
                    o_res.msg_type    <= r_type;
                    o_res.field_index <= r_field;
                    o_res.field_value <= w_acc;
                    o_res.field_bytes <= w_w;
                    o_res.last_field  <= w_nextw == '0;
                    o_res.bad_type    <= 1'b0;
                    r_acc   <= '0;
                    r_field <= r_field + 5'd1;
                    r_left  <= w_nextw;
                end else begin
                    r_acc  <= w_acc;
                    r_left <= r_left - 4'd1;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.bad_type |-> o_res.field_bytes == '0 && o_res.field_value == '0)
        else $error("error result carries data");
    a_width_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.bad_type |-> o_res.field_bytes != '0)
        else $error("field result with zero width");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res))
        else $error("result changed while stalled");
`endif
endmodule

// ----- design/itch_message_field_extractor.sv -----
// Top level: ITCH message field extractor, front classifier, queue and field builder.
// Takes one stream byte per cycle while the output is not stalled, and gives at most one
// field result per byte. An accepted byte passes through the front register, the queue
// and the field register of the back end before its result is shown.
// An unknown type letter gives one result with bad_type set and all else zero; the next
// byte is then taken as a type letter. The queue holds up to QueueDepth items, so the
// front keeps taking bytes while results are held back, until the queue is full.
module itch_message_field_extractor #(
    parameter int QueueDepth = itch_pkg::QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_message_type,
    output logic [4:0]  o_field_index,
    output logic [63:0] o_field_value,
    output logic [3:0]  o_field_bytes,
    output logic        o_last_field,
    output logic        o_bad_type
);
    itch_pkg::t_item   w_f_item, w_q_item;
    itch_pkg::t_result w_res;
    logic w_f_valid, w_f_ready, w_q_valid, w_q_ready;

    itch_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data_byte,
        .o_valid(w_f_valid), .i_ready(w_f_ready), .o_item(w_f_item)
    );

    itch_fifo #(.Depth(QueueDepth)) u_fifo (
        .i_clk, .i_rst_n,
        .i_valid(w_f_valid), .o_ready(w_f_ready), .i_item(w_f_item),
        .o_valid(w_q_valid), .i_ready(w_q_ready), .o_item(w_q_item)
    );

    itch_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_q_valid), .o_ready(w_q_ready), .i_item(w_q_item),
        .o_valid, .i_ready, .o_res(w_res)
    );

    assign o_message_type = w_res.msg_type;
    assign o_field_index  = w_res.field_index;
    assign o_field_value  = w_res.field_value;
    assign o_field_bytes  = w_res.field_bytes;
    assign o_last_field   = w_res.last_field;
    assign o_bad_type     = w_res.bad_type;
endmodule
